// ===== hw/rtl/team_grouped_fifo_core_defines.svh =====
// Assertion macros used by the team grouped FIFO core.
`ifndef TEAM_GROUPED_FIFO_CORE_DEFINES_SVH
`define TEAM_GROUPED_FIFO_CORE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define TGF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tgf check failed: same-cycle rule");

// Condition must hold in the cycle after the trigger.
`define TGF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tgf check failed: next-cycle rule");

`endif

// ===== hw/rtl/tgf_pkg.sv =====
// Package: sizes, types and status codes of the team grouped FIFO.
`default_nettype none

package tgf_pkg;

    localparam int TEAMS     = 16;
    localparam int ENTRIES   = 256;
    localparam int TEAM_W    = $clog2(TEAMS);
    localparam int ENTRY_W   = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int ELEM_W    = 16;
    localparam int TEAM_IN_W = 4;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    typedef enum logic [1:0] {
        STAT_ENQUEUED  = 2'd0,
        STAT_DEQUEUED  = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // Operation kind carried in s_tuser
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/team_grouped_fifo_core.sv =====
// Team grouped FIFO: a team queue over linked element memories.
//
// Input channel s_*: one word per operation. s_tuser is the kind
// (0 enqueue, 1 dequeue); s_tdata carries team and element value.
// Result channel m_*: exactly one word per operation with status in
// m_tuser and the removed value and the occupancy in m_tdata.
// In the accept cycle an operation issues the reads of the free ring and
// of the element and link memories (registered reads); in the execute
// state it writes them back and loads the result register. A new word is
// accepted only once the previous operation has left the execute state.
// The result register decouples the sides: a new word is accepted while
// an earlier result waits. If that result is still held when the next
// one is ready, the block waits in its execute state until m_tready.
// Reset (aresetn low, synchronous) empties the queue: the free ring reads
// as slots 0 upward until written, so no clearing pass is needed and the
// block is ready as soon as reset is released.
`default_nettype none

module team_grouped_fifo_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input words
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tgf_pkg::S_DATA_W-1:0]  s_tdata,  // team[3:0], element[19:4], zero pad
    input  wire logic                          s_tuser,  // action
    // result words
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [tgf_pkg::M_DATA_W-1:0]  m_tdata,  // dequeued_element[15:0], occupancy[24:16]
    output logic      [1:0]                    m_tuser   // status
);

    import tgf_pkg::*;

    `include "team_grouped_fifo_core_defines.svh"

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t               state_reg;
    logic                 act_reg;
    logic [TEAM_W-1:0]    team_reg;
    logic [ELEM_W-1:0]    elem_reg;
    logic [TEAM_W-1:0]    dteam_reg;
    logic [ENTRY_W-1:0]   dslot_reg;
    logic                 ring_ok_reg;

    logic [CNT_W-1:0]     cnt_reg;
    logic [ENTRY_W-1:0]   frd_ptr_reg;
    logic [ENTRY_W-1:0]   fwr_ptr_reg;
    logic                 fwrap_reg;

    logic [ENTRY_W-1:0]   head_reg [TEAMS];
    logic [ENTRY_W-1:0]   tail_reg [TEAMS];
    logic [TEAMS-1:0]     present_reg;
    logic [TEAM_W-1:0]    order_reg [TEAMS];
    logic [TEAM_W-1:0]    ohead_reg;
    logic [TEAM_W-1:0]    otail_reg;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    status_t              m_tuser_reg;

    logic                 accept;
    logic                 fire;
    logic                 full;
    logic                 empty;
    logic                 enq_ok;
    logic                 deq_ok;
    logic [TEAM_W-1:0]    deq_team;
    logic [ENTRY_W-1:0]   deq_slot;
    logic [ENTRY_W-1:0]   ring_q;
    logic [ENTRY_W-1:0]   new_slot;
    logic [ELEM_W-1:0]    elem_q;
    logic [ENTRY_W-1:0]   link_q;
    logic [CNT_W-1:0]     cnt_next;
    status_t              status_next;
    logic [ELEM_W-1:0]    removed_next;
    logic                 link_we;

    // handshake and operation decode
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign full     = (cnt_reg >= CNT_W'(ENTRIES));
    assign empty    = (cnt_reg == '0);
    assign enq_ok   = (act_reg == ACT_ENQ) && !full;
    assign deq_ok   = (act_reg == ACT_DEQ) && !empty;

    // front group lookup for a dequeue, done in the accept cycle
    assign deq_team = order_reg[ohead_reg];
    assign deq_slot = head_reg[deq_team];

    // slot handed out by the free ring; unwritten ring entries hold their index
    assign new_slot = ring_ok_reg ? ring_q : frd_ptr_reg;
    assign link_we  = fire && enq_ok && present_reg[team_reg];

    tgf_ram #(.WIDTH(ELEM_W), .DEPTH(ENTRIES)) u_elem_ram (
        .aclk    (aclk),
        .wr_en   (fire && enq_ok),
        .wr_addr (new_slot),
        .wr_data (elem_reg),
        .rd_en   (accept),
        .rd_addr (deq_slot),
        .rd_data (elem_q)
    );

    tgf_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (tail_reg[team_reg]),
        .wr_data (new_slot),
        .rd_en   (accept),
        .rd_addr (deq_slot),
        .rd_data (link_q)
    );

    tgf_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ring_ram (
        .aclk    (aclk),
        .wr_en   (fire && deq_ok),
        .wr_addr (fwr_ptr_reg),
        .wr_data (dslot_reg),
        .rd_en   (accept),
        .rd_addr (frd_ptr_reg),
        .rd_data (ring_q)
    );

    // result of the operation in flight
    always_comb begin
        cnt_next     = cnt_reg;
        removed_next = '0;
        status_next  = STAT_ENQUEUED;
        if (act_reg == ACT_ENQ) begin
            if (full) begin
                status_next = STAT_FULL;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                status_next = STAT_EMPTY;
            end else begin
                status_next  = STAT_DEQUEUED;
                removed_next = elem_q;
                cnt_next     = cnt_reg - CNT_W'(1);
            end
        end
    end

    // sequencer, pointers, counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            frd_ptr_reg  <= '0;
            fwr_ptr_reg  <= '0;
            fwrap_reg    <= 1'b0;
            present_reg  <= '0;
            ohead_reg    <= '0;
            otail_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (fire) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (fire) begin
                cnt_reg <= cnt_next;
                if (enq_ok) begin
                    frd_ptr_reg <= (frd_ptr_reg == ENTRY_W'(ENTRIES - 1)) ?
                                   '0 : frd_ptr_reg + ENTRY_W'(1);
                    if (!present_reg[team_reg]) begin
                        present_reg[team_reg] <= 1'b1;
                        otail_reg <= (otail_reg == TEAM_W'(TEAMS - 1)) ?
                                     '0 : otail_reg + TEAM_W'(1);
                    end
                end
                if (deq_ok) begin
                    if (fwr_ptr_reg == ENTRY_W'(ENTRIES - 1)) begin
                        fwr_ptr_reg <= '0;
                        fwrap_reg   <= 1'b1;
                    end else begin
                        fwr_ptr_reg <= fwr_ptr_reg + ENTRY_W'(1);
                    end
                    if (dslot_reg == tail_reg[dteam_reg]) begin
                        present_reg[dteam_reg] <= 1'b0;
                        ohead_reg <= (ohead_reg == TEAM_W'(TEAMS - 1)) ?
                                     '0 : ohead_reg + TEAM_W'(1);
                    end
                end
            end

            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // captured operation and group tables (payload, no reset)
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg     <= s_tuser;
            team_reg    <= TEAM_W'(s_tdata[TEAM_IN_W-1:0] % TEAMS);
            elem_reg    <= s_tdata[TEAM_IN_W +: ELEM_W];
            dteam_reg   <= deq_team;
            dslot_reg   <= deq_slot;
            ring_ok_reg <= fwrap_reg || (frd_ptr_reg < fwr_ptr_reg);
        end
        if (fire) begin
            m_tuser_reg <= status_next;
            m_tdata_reg <= {{(M_DATA_W - ELEM_W - CNT_W){1'b0}}, cnt_next, removed_next};
            if (enq_ok) begin
                tail_reg[team_reg] <= new_slot;
                if (!present_reg[team_reg]) begin
                    head_reg[team_reg]  <= new_slot;
                    order_reg[otail_reg] <= team_reg;
                end
            end
            if (deq_ok && (dslot_reg != tail_reg[dteam_reg])) begin
                head_reg[dteam_reg] <= link_q;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // consistency checks
    `TGF_ASSERT_NOW(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(ENTRIES))
    `TGF_ASSERT_NOW(a_empty_groups, aclk, aresetn, 1'b1, (cnt_reg == '0) == (present_reg == '0))
    `TGF_ASSERT_NOW(a_free_span, aclk, aresetn, 1'b1, ENTRY_W'(frd_ptr_reg - fwr_ptr_reg) == ENTRY_W'(cnt_reg))
    `TGF_ASSERT_NOW(a_order_len, aclk, aresetn, 1'b1, TEAM_W'($countones(present_reg)) == TEAM_W'(otail_reg - ohead_reg))
    `TGF_ASSERT_NEXT(a_deq_count, aclk, aresetn, fire && deq_ok, cnt_reg == $past(cnt_reg) - CNT_W'(1))

endmodule

`default_nettype wire

// ===== hw/rtl/tgf_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module tgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== tb/tb_team_grouped_fifo_core.sv =====
// Testbench for team_grouped_fifo_core: random and directed team queue traffic against a predictor.
`default_nettype none

module tb_team_grouped_fifo_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tgf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 9;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_WORD = 120;
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 450;
    localparam int MIXED_WORDS  = 170;
    localparam int FILL_WORDS   = ENTRIES + 4;
    localparam int DRAIN_WORDS  = ENTRIES + 6;

    // One queue operation as offered on the input channel
    typedef struct {
        logic               act;
        logic [TEAM_IN_W-1:0] team;
        logic [ELEM_W-1:0]  elem;
        bit                 drain_first;   // offer only once all results are out
    } queue_op_t;

    // One predicted result word
    typedef struct {
        status_t            status;
        logic [ELEM_W-1:0]  removed;
        logic [CNT_W-1:0]   occ;
    } queue_res_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;

    team_grouped_fifo_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // team[3:0], element[19:4], zero pad
        .s_tuser  (s_tuser),    // action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // dequeued_element[15:0], occupancy[24:16]
        .m_tuser  (m_tuser)     // status
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    queue_op_t  pending_ops[$];
    queue_res_t expected_res[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         words_in = 0;
    bit         word_taken = 1'b0;

    // Predictor state: linked element store, free slot ring, team order ring
    logic [ELEM_W-1:0]  elem_mem  [ENTRIES];
    logic [ENTRY_W-1:0] link_mem  [ENTRIES];
    logic [ENTRY_W-1:0] free_ring [ENTRIES];
    logic [ENTRY_W-1:0] free_rd = '0;
    logic [ENTRY_W-1:0] free_wr = '0;
    logic [ENTRY_W-1:0] grp_head  [TEAMS];
    logic [ENTRY_W-1:0] grp_tail  [TEAMS];
    logic               grp_live  [TEAMS];
    logic [TEAM_W-1:0]  order_ring[TEAMS];
    logic [TEAM_W-1:0]  ord_head = '0;
    logic [TEAM_W-1:0]  ord_tail = '0;
    logic [CNT_W-1:0]   held = '0;

    initial begin
        for (int k = 0; k < ENTRIES; k++) free_ring[k] = ENTRY_W'(k);
        for (int k = 0; k < TEAMS; k++) grp_live[k] = 1'b0;
    end

    // Advance the team queue by one operation and return its result word
    function automatic queue_res_t team_queue_step(input queue_op_t op);
        queue_res_t         r;
        logic [ENTRY_W-1:0] slot;
        logic [TEAM_W-1:0]  t;
        r.status  = STAT_ENQUEUED;
        r.removed = '0;
        if (op.act == ACT_ENQ) begin
            t = TEAM_W'(op.team);
            if (held >= ENTRIES) begin
                r.status = STAT_FULL;
            end else begin
                slot = free_ring[free_rd];
                free_rd = free_rd + 1'b1;
                elem_mem[slot] = op.elem;
                if (grp_live[t]) begin
                    // join behind the last queued member of the team
                    link_mem[grp_tail[t]] = slot;
                    grp_tail[t] = slot;
                end else begin
                    // open a new group at the tail of the team order
                    grp_head[t] = slot;
                    grp_tail[t] = slot;
                    grp_live[t] = 1'b1;
                    order_ring[ord_tail] = t;
                    ord_tail = ord_tail + 1'b1;
                end
                held = held + 1'b1;
            end
        end else if (held == 0) begin
            r.status = STAT_EMPTY;
        end else begin
            t = order_ring[ord_head];
            slot = grp_head[t];
            r.removed = elem_mem[slot];
            if (slot == grp_tail[t]) begin
                // group emptied: team leaves the order
                grp_live[t] = 1'b0;
                ord_head = ord_head + 1'b1;
            end else begin
                grp_head[t] = link_mem[slot];
            end
            free_ring[free_wr] = slot;
            free_wr = free_wr + 1'b1;
            held = held - 1'b1;
            r.status = STAT_DEQUEUED;
        end
        r.occ = held;
        return r;
    endfunction

    function automatic void add_op(input logic act, input logic [TEAM_IN_W-1:0] team,
                                   input logic [ELEM_W-1:0] elem, input bit drain_first);
        queue_op_t op;
        op.act = act;
        op.team = team;
        op.elem = elem;
        op.drain_first = drain_first;
        pending_ops.push_back(op);
    endfunction

    function automatic bit quiet_window();
        return (words_in >= QUIET_FROM) && (words_in < QUIET_TO);
    endfunction

    // Rising edge: take accepted words, check results, watch the cycle limit
    always @(posedge aclk) begin
        queue_op_t  op;
        queue_res_t exp_r;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_team_grouped_fifo_core failed");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_res.size() == 0) begin
                    $display("%0t: result word with none expected: status %0d data %h",
                             $realtime, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_res.pop_front();
                    if (m_tuser !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, exp_r.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[15:0] !== exp_r.removed) begin
                        $display("%0t: dequeued_element expected %h actual %h",
                                 $realtime, exp_r.removed, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[24:16] !== exp_r.occ) begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $realtime, exp_r.occ, m_tdata[24:16]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                op = pending_ops.pop_front();
                expected_res.push_back(team_queue_step(op));
                word_taken = 1'b1;
                words_in++;
            end
        end
    end

    // Driver: offer the head of the pending queue at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !word_taken)) begin
            word_taken = 1'b0;
            if (pending_ops.size() > 0 &&
                !(pending_ops[0].drain_first && expected_res.size() != 0) &&
                (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_ops[0].act;
                s_tdata  <= {4'b0000, pending_ops[0].elem, pending_ops[0].team};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AT_WORD) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [TEAM_IN_W-1:0] team_set[16];
        int n_teams;
        int burst;
        int pick;

        // directed: empty dequeue, field extremes, interleaved groups
        add_op(ACT_DEQ, 4'hF, 16'hFFFF, 1'b0);
        add_op(ACT_ENQ, 4'h0, 16'h0000, 1'b0);
        add_op(ACT_ENQ, 4'hF, 16'hFFFF, 1'b0);
        add_op(ACT_ENQ, 4'h0, 16'h1234, 1'b0);
        add_op(ACT_ENQ, 4'h5, 16'hA5A5, 1'b0);
        add_op(ACT_ENQ, 4'hF, 16'h5A5A, 1'b0);
        add_op(ACT_ENQ, 4'h0, 16'hFFFF, 1'b0);
        add_op(ACT_ENQ, 4'hA, 16'h0001, 1'b0);
        for (int k = 0; k < 7; k++) add_op(ACT_DEQ, 4'(k), 16'(k * 4099), 1'b0);
        // a team whose group emptied reopens at the tail
        add_op(ACT_ENQ, 4'h0, 16'h8000, 1'b0);
        add_op(ACT_ENQ, 4'hA, 16'h7FFF, 1'b0);
        add_op(ACT_DEQ, 4'h0, 16'h0000, 1'b0);
        add_op(ACT_DEQ, 4'h0, 16'h0000, 1'b0);
        add_op(ACT_DEQ, 4'h0, 16'h0000, 1'b0);
        add_op(ACT_DEQ, 4'h5, 16'hFFFF, 1'b0);

        // random: enqueue bursts over a team subset, then dequeue bursts, plus noise
        while (pending_ops.size() < MIXED_WORDS) begin
            if ($urandom_range(0, 9) < 7) begin
                n_teams = $urandom_range(1, 16);
                for (int k = 0; k < 16; k++) team_set[k] = 4'($urandom_range(0, 15));
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst; k++) begin
                    pick = $urandom_range(0, n_teams - 1);
                    add_op(ACT_ENQ, team_set[pick], 16'($urandom()), 1'b0);
                end
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst; k++)
                    add_op(ACT_DEQ, 4'($urandom_range(0, 15)), 16'($urandom()), 1'b0);
            end else begin
                burst = $urandom_range(1, 10);
                for (int k = 0; k < burst; k++)
                    add_op(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                           16'($urandom()), k == 0 && pending_ops.size() > 150);
            end
        end

        // fill past full after a drain pause, then empty past empty
        for (int k = 0; k < FILL_WORDS; k++)
            add_op(ACT_ENQ, 4'($urandom_range(0, 15)), 16'($urandom()), k == 0);
        for (int k = 0; k < DRAIN_WORDS; k++)
            add_op(ACT_DEQ, 4'($urandom_range(0, 15)), 16'($urandom()), 1'b0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || expected_res.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb_team_grouped_fifo_core passed");
        end else begin
            $display("tb_team_grouped_fifo_core failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
